@@ hdl/ncp_pkg.sv @@
// ---------------------------------------------------------------------------
// ncp_pkg
// Types and widths shared by the normalized cross product pipeline.
// ---------------------------------------------------------------------------
package ncp_pkg;

    localparam int CompW  = 16;
    localparam int ProdW  = 32;
    localparam int CrossW = 33;
    localparam int MagW   = 32;
    localparam int SumW   = 64;
    localparam int FracW  = 14;
    localparam int QuoW   = 15;
    localparam int RemW   = 34;
    localparam int DivW   = MagW + FracW + 1;

    typedef struct packed {
        logic signed [CompW-1:0] ax;
        logic signed [CompW-1:0] ay;
        logic signed [CompW-1:0] az;
        logic signed [CompW-1:0] bx;
        logic signed [CompW-1:0] by_comp;
        logic signed [CompW-1:0] bz;
    } t_in_word;

    typedef struct packed {
        logic signed [CompW-1:0] nx;
        logic signed [CompW-1:0] ny;
        logic signed [CompW-1:0] nz;
        logic                    degenerate;
    } t_out_word;

    typedef struct packed {
        logic signed [CrossW-1:0] cx;
        logic signed [CrossW-1:0] cy;
        logic signed [CrossW-1:0] cz;
    } t_cross;

endpackage

@@ hdl/normalized_cross_product.sv @@
// ---------------------------------------------------------------------------
// normalized_cross_product
// Unit-length cross product of two Q4.12 vectors, Q2.14 result.
// ---------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one word with two vectors a and b.
// Output channel: o_valid / i_stall carry one word with the unit normal and
// a degenerate flag, set with a zero vector when a x b is exactly zero.
// A word moves at a rising edge where valid is high and stall is low.
// Throughput: one word per cycle while the output is not stalled. A word
// passes through products and sum of squares, the square root at one root
// bit per stage, the dividers at one quotient bit per stage, and the output
// register before o_valid.
// When the output word is held by i_stall, the whole pipeline freezes and
// o_stall rises in the same cycle; no word is lost or repeated.
// Reset (i_rst_n low at a clock edge) clears all valid bits; words in
// flight are dropped. The data registers are not reset.
// ---------------------------------------------------------------------------
module normalized_cross_product (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  ncp_pkg::t_in_word   i_word,
    output logic                o_valid,
    input  logic                i_stall,
    output ncp_pkg::t_out_word  o_word
);

    logic                            n_en;
    logic                            w_x_vld;
    ncp_pkg::t_cross                 w_x_cross;
    logic [ncp_pkg::SumW-1:0]        w_x_sum;
    logic                            w_r_vld;
    ncp_pkg::t_cross                 w_r_cross;
    logic [ncp_pkg::MagW-1:0]        w_r_root;
    logic [2:0]                      w_d_vld;
    logic [2:0]                      w_d_deg;
    logic signed [ncp_pkg::CompW-1:0] w_n [0:2];
    logic                            r_out_vld;
    ncp_pkg::t_out_word              r_out;

    assign n_en    = !(r_out_vld && i_stall);
    assign o_stall = !n_en;

    ncp_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_vld   (i_valid),
        .i_word  (i_word),
        .o_vld   (w_x_vld),
        .o_cross (w_x_cross),
        .o_sum   (w_x_sum)
    );

    ncp_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_vld   (w_x_vld),
        .i_cross (w_x_cross),
        .i_sum   (w_x_sum),
        .o_vld   (w_r_vld),
        .o_cross (w_r_cross),
        .o_root  (w_r_root)
    );

    ncp_div u_div_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (n_en), .i_vld (w_r_vld),
        .i_c (w_r_cross.cx), .i_d (w_r_root),
        .o_vld (w_d_vld[0]), .o_n (w_n[0]), .o_deg (w_d_deg[0])
    );

    ncp_div u_div_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (n_en), .i_vld (w_r_vld),
        .i_c (w_r_cross.cy), .i_d (w_r_root),
        .o_vld (w_d_vld[1]), .o_n (w_n[1]), .o_deg (w_d_deg[1])
    );

    ncp_div u_div_z (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (n_en), .i_vld (w_r_vld),
        .i_c (w_r_cross.cz), .i_d (w_r_root),
        .o_vld (w_d_vld[2]), .o_n (w_n[2]), .o_deg (w_d_deg[2])
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (n_en) begin
            r_out_vld <= w_d_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_out.nx         <= w_n[0];
            r_out.ny         <= w_n[1];
            r_out.nz         <= w_n[2];
            r_out.degenerate <= w_d_deg[0];
        end
    end

    assign o_valid = r_out_vld;
    assign o_word  = r_out;

`ifndef SYNTHESIS
    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_d_vld[0] == w_d_vld[1]) && (w_d_vld[0] == w_d_vld[2])
        && (!w_d_vld[0]
            || ((w_d_deg[0] == w_d_deg[1]) && (w_d_deg[0] == w_d_deg[2]))))
        else $error("divider lanes out of step");

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word.degenerate) |->
        (o_word.nx == '0 && o_word.ny == '0 && o_word.nz == '0))
        else $error("degenerate word with nonzero normal");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_word.nx >= -16'sd16384 && o_word.nx <= 16'sd16384
                  && o_word.ny >= -16'sd16384 && o_word.ny <= 16'sd16384
                  && o_word.nz >= -16'sd16384 && o_word.nz <= 16'sd16384))
        else $error("normal component out of range");

    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");
`endif

endmodule

@@ hdl/ncp_cross.sv @@
// ---------------------------------------------------------------------------
// ncp_cross
// Four stages: products, cross differences, squares, sum of squares.
// ---------------------------------------------------------------------------
module ncp_cross (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_vld,
    input  ncp_pkg::t_in_word               i_word,
    output logic                            o_vld,
    output ncp_pkg::t_cross                 o_cross,
    output logic [ncp_pkg::SumW-1:0]        o_sum
);

    logic [3:0]                       r_vld;
    logic signed [ncp_pkg::ProdW-1:0] r_p [0:5];
    ncp_pkg::t_cross                  r_c2;
    ncp_pkg::t_cross                  r_c3;
    ncp_pkg::t_cross                  r_c4;
    logic [ncp_pkg::SumW-1:0]         r_sq [0:2];
    logic [ncp_pkg::SumW-1:0]         r_sum;
    logic [ncp_pkg::MagW-1:0]         n_mag [0:2];
    logic signed [ncp_pkg::CrossW-1:0] n_neg [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
    end

    always_comb begin
        n_neg[0] = -r_c2.cx;
        n_neg[1] = -r_c2.cy;
        n_neg[2] = -r_c2.cz;
        n_mag[0] = r_c2.cx[ncp_pkg::CrossW-1] ? n_neg[0][ncp_pkg::MagW-1:0]
                                               : r_c2.cx[ncp_pkg::MagW-1:0];
        n_mag[1] = r_c2.cy[ncp_pkg::CrossW-1] ? n_neg[1][ncp_pkg::MagW-1:0]
                                               : r_c2.cy[ncp_pkg::MagW-1:0];
        n_mag[2] = r_c2.cz[ncp_pkg::CrossW-1] ? n_neg[2][ncp_pkg::MagW-1:0]
                                               : r_c2.cz[ncp_pkg::MagW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= i_word.ay * i_word.bz;
            r_p[1] <= i_word.az * i_word.by_comp;
            r_p[2] <= i_word.az * i_word.bx;
            r_p[3] <= i_word.ax * i_word.bz;
            r_p[4] <= i_word.ax * i_word.by_comp;
            r_p[5] <= i_word.ay * i_word.bx;
            r_c2.cx <= ncp_pkg::CrossW'(r_p[0]) - ncp_pkg::CrossW'(r_p[1]);
            r_c2.cy <= ncp_pkg::CrossW'(r_p[2]) - ncp_pkg::CrossW'(r_p[3]);
            r_c2.cz <= ncp_pkg::CrossW'(r_p[4]) - ncp_pkg::CrossW'(r_p[5]);
            r_c3 <= r_c2;
            for (int j = 0; j < 3; j++) begin
                r_sq[j] <= ncp_pkg::SumW'(n_mag[j]) * ncp_pkg::SumW'(n_mag[j]);
            end
            r_c4  <= r_c3;
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    assign o_vld   = r_vld[3];
    assign o_cross = r_c4;
    assign o_sum   = r_sum;

endmodule

@@ hdl/ncp_isqrt.sv @@
// ---------------------------------------------------------------------------
// ncp_isqrt
// Integer square root, one root bit per stage, 32 stages.
// ---------------------------------------------------------------------------
module ncp_isqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_vld,
    input  ncp_pkg::t_cross                 i_cross,
    input  logic [ncp_pkg::SumW-1:0]        i_sum,
    output logic                            o_vld,
    output ncp_pkg::t_cross                 o_cross,
    output logic [ncp_pkg::MagW-1:0]        o_root
);

    localparam int Steps = ncp_pkg::MagW;
    localparam int TrW   = ncp_pkg::RemW + 2;

    logic [Steps:0]                  r_vld;
    logic [ncp_pkg::RemW-1:0]        r_rem  [0:Steps];
    logic [ncp_pkg::MagW-1:0]        r_root [0:Steps];
    logic [ncp_pkg::SumW-1:0]        r_rad  [0:Steps];
    ncp_pkg::t_cross                 r_c    [0:Steps];

    always_comb begin
        r_vld[0]  = i_vld;
        r_rem[0]  = '0;
        r_root[0] = '0;
        r_rad[0]  = i_sum;
        r_c[0]    = i_cross;
    end

    for (genvar k = 0; k < Steps; k++) begin : g_step
        logic [TrW-1:0]           n_rs;
        logic [TrW-1:0]           n_tr;
        logic                     n_ge;
        logic [TrW-1:0]           n_diff;

        always_comb begin
            n_rs   = {r_rem[k], r_rad[k][ncp_pkg::SumW-1 -: 2]};
            n_tr   = {2'b00, r_root[k], 2'b01};
            n_ge   = (n_rs >= n_tr);
            n_diff = n_ge ? (n_rs - n_tr) : n_rs;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= n_diff[ncp_pkg::RemW-1:0];
                r_root[k+1] <= {r_root[k][ncp_pkg::MagW-2:0], n_ge};
                r_rad[k+1]  <= {r_rad[k][ncp_pkg::SumW-3:0], 2'b00};
                r_c[k+1]    <= r_c[k];
            end
        end
    end

    assign o_vld   = r_vld[Steps];
    assign o_cross = r_c[Steps];
    assign o_root  = r_root[Steps];

endmodule

@@ hdl/ncp_div.sv @@
// ---------------------------------------------------------------------------
// ncp_div
// Restoring divider, one quotient bit per stage: trunc(c * 2^14 / d).
// ---------------------------------------------------------------------------
module ncp_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_vld,
    input  logic signed [ncp_pkg::CrossW-1:0]  i_c,
    input  logic [ncp_pkg::MagW-1:0]           i_d,
    output logic                               o_vld,
    output logic signed [ncp_pkg::CompW-1:0]   o_n,
    output logic                               o_deg
);

    localparam int Steps = ncp_pkg::QuoW;
    localparam int DW    = ncp_pkg::DivW;

    logic [Steps:0]                  r_vld;
    logic [DW-1:0]                   r_rem [0:Steps];
    logic [ncp_pkg::MagW-1:0]        r_d   [0:Steps];
    logic [ncp_pkg::QuoW-1:0]        r_q   [0:Steps];
    logic                            r_sgn [0:Steps];
    logic signed [ncp_pkg::CrossW-1:0] n_negc;
    logic [ncp_pkg::MagW-1:0]        n_mag;
    logic [ncp_pkg::CompW-1:0]       n_q16;

    always_comb begin
        n_negc    = -i_c;
        n_mag     = i_c[ncp_pkg::CrossW-1] ? n_negc[ncp_pkg::MagW-1:0]
                                           : i_c[ncp_pkg::MagW-1:0];
        r_vld[0]  = i_vld;
        r_rem[0]  = {1'b0, n_mag, {ncp_pkg::FracW{1'b0}}};
        r_d[0]    = i_d;
        r_q[0]    = '0;
        r_sgn[0]  = i_c[ncp_pkg::CrossW-1];
    end

    for (genvar k = 0; k < Steps; k++) begin : g_step
        logic [DW-1:0] n_sub;
        logic          n_ge;

        always_comb begin
            n_sub = DW'(r_d[k]) << (Steps - 1 - k);
            n_ge  = (r_rem[k] >= n_sub);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= n_ge ? (r_rem[k] - n_sub) : r_rem[k];
                r_q[k+1]   <= {r_q[k][ncp_pkg::QuoW-2:0], n_ge};
                r_d[k+1]   <= r_d[k];
                r_sgn[k+1] <= r_sgn[k];
            end
        end
    end

    always_comb begin
        n_q16 = {1'b0, r_q[Steps]};
        o_deg = (r_d[Steps] == '0);
        if (o_deg) begin
            o_n = '0;
        end else if (r_sgn[Steps]) begin
            o_n = -$signed(n_q16);
        end else begin
            o_n = $signed(n_q16);
        end
    end

    assign o_vld = r_vld[Steps];

endmodule
